/* rtl/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
// Operation, status and command codes used by the front end, back end, top level and checkers.
// No dependencies.
package deq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int VALUE_W = 32;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE,
    STATUS_EMPTY,
    STATUS_FULL
  } status_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PUSH_FRONT,
    KIND_PUSH_BACK,
    KIND_POP_FRONT,
    KIND_POP_BACK
  } kind_t;

  typedef struct packed {
    kind_t   kind;
    logic    was_empty;
    status_t status;
  } ctrl_t;

  localparam int CTRL_W = $bits(ctrl_t);

endpackage

/* rtl/deq_in_if.sv */
// Request channel of the double-ended queue: one operation per transaction.
// Depends on nothing beyond the field widths of the block.
interface deq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink (input valid, input op, input push_value, output ready);
endinterface

/* rtl/deq_out_if.sv */
// Result channel of the double-ended queue: one result per transaction.
// Depends on nothing beyond the field widths of the block.
interface deq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [4:0]         entry_count;
  logic [1:0]         status;

  modport source (output valid, output front_value, output back_value,
                  output entry_count, output status, input ready);
  modport sink (input valid, input front_value, input back_value,
                input entry_count, input status, output ready);
endinterface

/* rtl/deq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/deq_front.sv */
// Front end of the double-ended queue: accepts operations, tracks the front
// index and the count, and turns each transaction into a command.
// Depends on deq_pkg and deq_in_if.
module deq_front #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  deq_in_if.sink                         request,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output deq_pkg::ctrl_t                 cmd_ctrl,
  output logic [$clog2(CAPACITY)-1:0]    cmd_addr,
  output logic [$clog2(CAPACITY+1)-1:0]  cmd_count,
  output logic [deq_pkg::VALUE_W-1:0]    cmd_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);

  logic [AW-1:0] front_index;
  logic [AW-1:0] front_index_next;
  logic [CW-1:0] item_count;
  logic          full;
  logic          empty;
  logic [SW-1:0] offset;
  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;
  deq_pkg::op_t  op;
  logic          accept;

  assign op        = deq_pkg::op_t'(request.op);
  assign full      = (item_count == CW'(CAPACITY));
  assign empty     = (item_count == '0);
  assign cmd_valid = request.valid;
  assign request.ready = cmd_ready;
  assign accept    = request.valid && cmd_ready;
  assign cmd_data  = request.push_value;

  always_comb begin
    case (op)
      deq_pkg::OP_POP_FRONT: offset = SW'(1);
      deq_pkg::OP_POP_BACK:  offset = SW'(item_count) - SW'(2);
      default:               offset = SW'(item_count);
    endcase
    sum     = SW'(front_index) + offset;
    wrapped = (sum >= CAP_S) ? sum - CAP_S : sum;
  end

  always_comb begin
    front_index_next   = front_index;
    cmd_ctrl.kind      = deq_pkg::KIND_NONE;
    cmd_ctrl.was_empty = empty;
    cmd_ctrl.status    = deq_pkg::STATUS_DONE;
    cmd_addr           = wrapped[AW-1:0];
    cmd_count          = item_count;
    case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          cmd_ctrl.status = deq_pkg::STATUS_FULL;
        end else begin
          front_index_next = (front_index == '0) ? AW'(CAPACITY - 1) : front_index - AW'(1);
          cmd_ctrl.kind    = deq_pkg::KIND_PUSH_FRONT;
          cmd_addr         = front_index_next;
          cmd_count        = item_count + CW'(1);
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          cmd_ctrl.status = deq_pkg::STATUS_FULL;
        end else begin
          cmd_ctrl.kind = deq_pkg::KIND_PUSH_BACK;
          cmd_count     = item_count + CW'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          cmd_ctrl.status = deq_pkg::STATUS_EMPTY;
        end else begin
          front_index_next = wrapped[AW-1:0];
          cmd_ctrl.kind    = deq_pkg::KIND_POP_FRONT;
          cmd_count        = item_count - CW'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          cmd_ctrl.status = deq_pkg::STATUS_EMPTY;
        end else begin
          cmd_ctrl.kind = deq_pkg::KIND_POP_BACK;
          cmd_count     = item_count - CW'(1);
        end
      end
      default: begin
        cmd_ctrl.kind = deq_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      item_count  <= '0;
    end else if (accept) begin
      front_index <= front_index_next;
      item_count  <= cmd_count;
    end
  end

endmodule

/* rtl/deq_cmd_fifo.sv */
// Two-entry command queue between the front end and the back end.
// No dependencies.
module deq_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       used;
  logic             push;
  logic             pop;

  assign in_ready  = (used != 2'd2);
  assign out_valid = (used != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        used <= used + 2'd1;
      end else if (pop && !push) begin
        used <= used - 2'd1;
      end
    end
  end

endmodule

/* rtl/deq_back.sv */
// Back end of the double-ended queue: carries out commands on the slot store,
// keeps the front and back values and drives the result channel.
// Depends on deq_pkg, deq_out_if and deq_ram.
module deq_back #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  deq_pkg::ctrl_t                 cmd_ctrl,
  input  logic [$clog2(CAPACITY)-1:0]    cmd_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]  cmd_count,
  input  logic [deq_pkg::VALUE_W-1:0]    cmd_data,
  deq_out_if.source                      result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = deq_pkg::VALUE_W;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                state;
  logic [VW-1:0]         front_val;
  logic [VW-1:0]         back_val;
  logic                  pend_front;
  logic [CW-1:0]         pend_count;
  deq_pkg::status_t      pend_status;
  logic                  out_free;
  logic                  take;
  logic                  is_push;
  logic                  need_read;
  logic [VW-1:0]         fv_new;
  logic [VW-1:0]         bv_new;
  logic [VW-1:0]         fv_read;
  logic [VW-1:0]         bv_read;
  logic [VW-1:0]         rdata;
  logic [CW+4:0]         count_direct;
  logic [CW+4:0]         count_read;

  assign out_free  = !result.valid || result.ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;
  assign is_push   = (cmd_ctrl.kind == deq_pkg::KIND_PUSH_FRONT) ||
                     (cmd_ctrl.kind == deq_pkg::KIND_PUSH_BACK);
  assign need_read = ((cmd_ctrl.kind == deq_pkg::KIND_POP_FRONT) ||
                      (cmd_ctrl.kind == deq_pkg::KIND_POP_BACK)) && (cmd_count != '0);
  assign count_direct = (CW + 5)'(cmd_count);
  assign count_read   = (CW + 5)'(pend_count);

  deq_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_slot_store (
    .clk   (clk),
    .we    (take && is_push),
    .waddr (cmd_addr),
    .wdata (cmd_data),
    .re    (take && need_read),
    .raddr (cmd_addr),
    .rdata (rdata)
  );

  always_comb begin
    fv_new = front_val;
    bv_new = back_val;
    case (cmd_ctrl.kind)
      deq_pkg::KIND_PUSH_FRONT: begin
        fv_new = cmd_data;
        bv_new = cmd_ctrl.was_empty ? cmd_data : back_val;
      end
      deq_pkg::KIND_PUSH_BACK: begin
        bv_new = cmd_data;
        fv_new = cmd_ctrl.was_empty ? cmd_data : front_val;
      end
      default: begin
        fv_new = front_val;
      end
    endcase
    fv_read = pend_front ? rdata : front_val;
    bv_read = pend_front ? back_val : rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && !need_read) begin
            front_val          <= fv_new;
            back_val           <= bv_new;
            result.valid       <= 1'b1;
            result.front_value <= (cmd_count == '0) ? '0 : fv_new;
            result.back_value  <= (cmd_count == '0) ? '0 : bv_new;
            result.entry_count <= count_direct[deq_pkg::COUNT_OUT_W-1:0];
            result.status      <= cmd_ctrl.status;
          end else if (result.ready) begin
            result.valid <= 1'b0;
          end
          if (take && need_read) begin
            pend_front  <= (cmd_ctrl.kind == deq_pkg::KIND_POP_FRONT);
            pend_count  <= cmd_count;
            pend_status <= cmd_ctrl.status;
            state       <= S_READ;
          end
        end
        S_READ: begin
          front_val          <= fv_read;
          back_val           <= bv_read;
          result.valid       <= 1'b1;
          result.front_value <= fv_read;
          result.back_value  <= bv_read;
          result.entry_count <= count_read[deq_pkg::COUNT_OUT_W-1:0];
          result.status      <= pend_status;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/double_ended_queue_top.sv */
// Top level of the bounded double-ended queue of signed 32-bit values.
// Pushes and ignored operations: result registered as the back end takes the command;
// pops that leave the queue non-empty add one registered slot store read (S_READ),
// during which no command is taken. 1 push per cycle while the result channel is ready.
// Reset clears the front index, count, command queue and result valid;
// the slot store is not cleared and needs no clearing pass.
module double_ended_queue_top #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input logic       clk,
  input logic       rst,
  deq_in_if.sink    request,
  deq_out_if.source result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = deq_pkg::VALUE_W;
  localparam int FW = deq_pkg::CTRL_W + AW + CW + VW;

  logic                  f_valid;
  logic                  f_ready;
  deq_pkg::ctrl_t        f_ctrl;
  logic [AW-1:0]         f_addr;
  logic [CW-1:0]         f_count;
  logic [VW-1:0]         f_data;
  logic                  b_valid;
  logic                  b_ready;
  deq_pkg::ctrl_t        b_ctrl;
  logic [AW-1:0]         b_addr;
  logic [CW-1:0]         b_count;
  logic [VW-1:0]         b_data;
  logic [FW-1:0]         q_in;
  logic [FW-1:0]         q_out;

  deq_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_ctrl  (f_ctrl),
    .cmd_addr  (f_addr),
    .cmd_count (f_count),
    .cmd_data  (f_data)
  );

  assign q_in = {f_ctrl, f_addr, f_count, f_data};

  deq_cmd_fifo #(
    .WIDTH (FW)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (q_in),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (q_out)
  );

  assign {b_ctrl, b_addr, b_count, b_data} = q_out;

  deq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_ctrl  (b_ctrl),
    .cmd_addr  (b_addr),
    .cmd_count (b_count),
    .cmd_data  (b_data),
    .result    (result)
  );

endmodule

/* rtl/deq_checker.sv */
// Port-level checks on the result channel of the double-ended queue.
// Depends on deq_pkg; bound to double_ended_queue_top.
module deq_checker #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] front_value,
  input logic [31:0] back_value,
  input logic [4:0]  entry_count,
  input logic [1:0]  status
);

  localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (entry_count == 5'd0) |-> (front_value == '0) && (back_value == '0))
    else $error("Empty queue must report zero values.");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == deq_pkg::STATUS_EMPTY) |-> (entry_count == 5'd0))
    else $error("Ignored pop with non-zero count.");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == deq_pkg::STATUS_FULL) |-> (entry_count == CAP_LOW))
    else $error("Dropped push without a full queue.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(front_value) && $stable(back_value)
      && $stable(entry_count) && $stable(status))
    else $error("Stalled transaction changed.");

endmodule

bind double_ended_queue_top deq_checker #(
  .CAPACITY (CAPACITY)
) u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .front_value (result.front_value),
  .back_value  (result.back_value),
  .entry_count (result.entry_count),
  .status      (result.status)
);

/* test/deq_result_checker.sv */
`timescale 1ns / 1ps
// Checker for the double-ended queue: tracks its own copy of the queue from the
// request transactions and compares every result transaction with that copy.
// Depends on deq_pkg, deq_in_if and deq_out_if.
module deq_result_checker #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input logic  clk,
  input logic  rst,
  deq_in_if    request,
  deq_out_if   result,
  output int   fail_count,
  output int   outstanding
);

  typedef struct {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_count;
    deq_pkg::status_t   status;
  } deq_view_t;

  logic signed [31:0] shadow_slots [CAPACITY];
  int                 shadow_front;
  int                 shadow_count;
  deq_view_t          awaited_views [$];

  function automatic deq_view_t apply_operation(deq_pkg::op_t op, logic signed [31:0] value);
    deq_view_t view;
    view.status = deq_pkg::STATUS_DONE;
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          view.status = deq_pkg::STATUS_FULL;
        end else if (op == deq_pkg::OP_PUSH_FRONT) begin
          shadow_front = (shadow_front == 0) ? CAPACITY - 1 : shadow_front - 1;
          shadow_slots[shadow_front] = value;
          shadow_count++;
        end else begin
          shadow_slots[(shadow_front + shadow_count) % CAPACITY] = value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          view.status = deq_pkg::STATUS_EMPTY;
        end else begin
          if (op == deq_pkg::OP_POP_FRONT) begin
            shadow_front = (shadow_front + 1) % CAPACITY;
          end
          shadow_count--;
        end
      end
    endcase
    view.front_value = '0;
    view.back_value  = '0;
    if (shadow_count != 0) begin
      view.front_value = shadow_slots[shadow_front];
      view.back_value  = shadow_slots[(shadow_front + shadow_count - 1) % CAPACITY];
    end
    view.entry_count = 5'(shadow_count);
    return view;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deq_view_t want;
    if (rst) begin
      shadow_front = 0;
      shadow_count = 0;
      fail_count   = 0;
      awaited_views.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (awaited_views.size() == 0) begin
          $error("Result transaction with no operation waiting for it.");
          fail_count++;
        end else begin
          want = awaited_views.pop_front();
          check_field("front_value", want.front_value, result.front_value);
          check_field("back_value", want.back_value, result.back_value);
          check_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
          check_field("status", 32'(want.status), 32'(result.status));
        end
      end
      if (request.valid && request.ready) begin
        awaited_views.push_back(apply_operation(deq_pkg::op_t'(request.op),
                                                request.push_value));
      end
    end
    outstanding = awaited_views.size();
  end

endmodule

/* test/double_ended_queue_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: drives request transactions and
// result back-pressure, and reports the verdict of deq_result_checker.
// Depends on deq_pkg, both channel interfaces, the block and the checker.
module double_ended_queue_top_tb;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 200000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   outstanding;
  bit   sender_gaps;
  bit   receiver_stalls;
  bit   hold_off_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  deq_in_if  request_if ();
  deq_out_if result_if ();

  double_ended_queue_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_if),
    .result  (result_if)
  );

  deq_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .request     (request_if),
    .result      (result_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_op(deq_pkg::op_t op, logic signed [31:0] value);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      request_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_if.valid      <= 1'b1;
    request_if.op         <= op;
    request_if.push_value <= value;
    do @(posedge clk); while (request_if.ready !== 1'b1);
  endtask

  // The receiver holds off for a long stretch once so the block backs up
  // into the request channel.
  initial begin
    bit held_off;
    held_off        = 1'b0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held_off) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        held_off = 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic signed [31:0] value;
    bit                 pop_side;
    int                 push_pct;
    deq_pkg::op_t       op;

    rst                   = 1'b1;
    request_if.valid      = 1'b0;
    request_if.op         = deq_pkg::OP_PUSH_FRONT;
    request_if.push_value = '0;
    sender_gaps           = 1'b0;
    receiver_stalls       = 1'b0;
    hold_off_req          = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_op(deq_pkg::OP_POP_FRONT, 32'sh1234_5678);
    send_op(deq_pkg::OP_POP_BACK, -32'sd1);
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: value = 32'sh7FFF_FFFF;
        1: value = 32'sh8000_0000;
        2: value = -32'sd1 - i;
        default: value = 32'(i) * 32'h0101_0101;
      endcase
      send_op((i % 2 == 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK, value);
    end
    send_op(deq_pkg::OP_PUSH_FRONT, 32'sd7);
    send_op(deq_pkg::OP_PUSH_BACK, 32'sd8);
    send_op(deq_pkg::OP_POP_FRONT, '0);
    send_op(deq_pkg::OP_POP_BACK, '0);
    send_op(deq_pkg::OP_PUSH_BACK, 32'sh5A5A_A5A5);

    for (int phase = 0; phase < 8; phase++) begin
      sender_gaps     = (phase < 6) && (phase != 2);
      receiver_stalls = (phase < 6);
      if (phase == 2) begin
        hold_off_req = 1'b1;
      end
      push_pct = (phase % 2 == 0) ? 70 : 30;
      for (int n = 0; n < 50; n++) begin
        pop_side = ($urandom_range(0, 99) >= push_pct);
        op = deq_pkg::op_t'({pop_side, 1'($urandom_range(0, 1))});
        case ($urandom_range(0, 7))
          0: value = 32'sh7FFF_FFFF;
          1: value = 32'sh8000_0000;
          2: value = '0;
          3: value = '1;
          default: value = $urandom();
        endcase
        send_op(op, value);
      end
    end

    @(negedge clk);
    request_if.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
